[rtl/hva_pkg.sv]
`timescale 1ns / 1ps

package hva_pkg;

    localparam int WORD_W        = 32;
    localparam int LANES         = 4;
    localparam int TOL_W         = 16;
    localparam int FRAC_BITS_DEF = 16;
    // Sum of four squares below 2^62 gives a root of at most 31 bits.
    localparam int RAD_W         = 62;
    localparam int ROOT_W        = RAD_W / 2;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_SCALE = 4'd2,
        OP_NEG   = 4'd3,
        OP_DOT   = 4'd4,
        OP_CROSS = 4'd5,
        OP_MAG   = 4'd6,
        OP_NORM  = 4'd7,
        OP_EQUAL = 4'd8
    } op_t;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_BAD_W      = 2'd1;
    localparam logic [1:0] ERR_NON_VECTOR = 2'd2;
    localparam logic [1:0] ERR_ZERO_LEN   = 2'd3;

    typedef struct packed {
        logic [3:0]          req_type;
        logic signed [31:0]  a_x;
        logic signed [31:0]  a_y;
        logic signed [31:0]  a_z;
        logic signed [31:0]  a_w;
        logic signed [31:0]  b_x;
        logic signed [31:0]  b_y;
        logic signed [31:0]  b_z;
        logic signed [31:0]  b_w;
        logic signed [31:0]  scale_factor;
    } in_t;

    typedef struct packed {
        logic signed [31:0]  res_x;
        logic signed [31:0]  res_y;
        logic signed [31:0]  res_z;
        logic signed [31:0]  res_w;
        logic signed [31:0]  scalar_out;
        logic                tuples_equal;
        logic                a_is_point;
        logic                a_is_vector;
        logic [1:0]          error_code;
        logic                overflow_flag;
    } out_t;

    // Per-request flags worked out at the input.
    typedef struct packed {
        op_t   op;
        logic  a_point;
        logic  a_vector;
        logic  eq;
        logic  wbad;
    } ctl_t;

    // What one lane hands to the merging stage.
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     ov;
        logic signed [63:0]       part;
        logic [WORD_W-1:0]        amag;
        logic                     aneg;
    } lane_out_t;

    // Request state carried through the root and divide pipelines.
    typedef struct packed {
        op_t                           op;
        logic [LANES-1:0][WORD_W-1:0]  res;
        logic [WORD_W-1:0]             scalar;
        logic                          eq;
        logic                          a_point;
        logic                          a_vector;
        logic [1:0]                    err;
        logic                          ov;
        logic                          sat_mag;
        logic [LANES-1:0][WORD_W-1:0]  amag;
        logic [LANES-1:0]              aneg;
        logic [WORD_W-1:0]             mag;
    } mid_t;

    function automatic logic [WORD_W:0] sat32(input logic signed [63:0] v);
        logic [WORD_W:0] r;
        if (v > 64'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[WORD_W-1:0]};
        end
        return r;
    endfunction

    function automatic logic agree(input logic signed [33:0] p,
                                   input logic signed [33:0] q,
                                   input logic [TOL_W-1:0] tol);
        logic signed [34:0] d;
        logic [34:0]        m;
        d = 35'(p) - 35'(q);
        m = d[34] ? 35'(-d) : 35'(d);
        return m <= 35'(tol);
    endfunction

endpackage

[rtl/hva_lane.sv]
`timescale 1ns / 1ps

module hva_lane
    import hva_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int LANE      = 0
)
(
    input  logic                          clk,
    input  logic                          en,
    input  op_t                           op,
    input  logic [LANES-1:0][WORD_W-1:0]  a_vec,
    input  logic [LANES-1:0][WORD_W-1:0]  b_vec,
    input  word_t                         s,
    output lane_out_t                     lane_out
);

    // Cross product operand indexes for this lane.
    localparam int C1 = (LANE + 1) % 3;
    localparam int C2 = (LANE + 2) % 3;

    word_t ai;
    word_t bi;
    word_t m0a;
    word_t m0b;
    word_t m1a;
    word_t m1b;

    logic signed [63:0]     p0_next;
    logic signed [63:0]     p1_next;
    logic signed [WORD_W:0] raw_next;
    logic [WORD_W-1:0]      amag_next;

    logic signed [63:0]     p0_reg;
    logic signed [63:0]     p1_reg;
    logic signed [WORD_W:0] raw_reg;
    logic [WORD_W-1:0]      amag_reg;
    logic                   aneg_reg;
    op_t                    op_reg;

    logic signed [63:0]     sh0;
    logic signed [63:0]     sh1;
    lane_out_t              lane_next;
    lane_out_t              lane_reg;

    assign ai = word_t'(a_vec[LANE]);
    assign bi = word_t'(b_vec[LANE]);

    always_comb
    begin
        m0a      = '0;
        m0b      = '0;
        m1a      = '0;
        m1b      = '0;
        raw_next = '0;
        case (op)
            OP_ADD:   raw_next = 33'(ai) + 33'(bi);
            OP_SUB:   raw_next = 33'(ai) - 33'(bi);
            OP_NEG:   raw_next = 33'sd0 - 33'(ai);
            OP_SCALE:
            begin
                m0a = ai;
                m0b = s;
            end
            OP_DOT:
            begin
                m0a = ai;
                m0b = bi;
            end
            OP_CROSS:
            begin
                m0a = word_t'(a_vec[C1]);
                m0b = word_t'(b_vec[C2]);
                m1a = word_t'(a_vec[C2]);
                m1b = word_t'(b_vec[C1]);
            end
            OP_MAG, OP_NORM:
            begin
                m0a = ai;
                m0b = ai;
            end
            default: ;
        endcase
    end

    assign p0_next   = m0a * m0b;
    assign p1_next   = m1a * m1b;
    assign amag_next = ai[WORD_W-1] ? (~a_vec[LANE] + 32'd1) : a_vec[LANE];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            raw_reg  <= raw_next;
            amag_reg <= amag_next;
            aneg_reg <= ai[WORD_W-1];
            op_reg   <= op;
        end
    end

    // Products, not squares, are floored to the fixed-point grid.
    assign sh0 = p0_reg >>> FRAC_BITS;
    assign sh1 = p1_reg >>> FRAC_BITS;

    always_comb
    begin
        lane_next       = '0;
        lane_next.amag  = amag_reg;
        lane_next.aneg  = aneg_reg;
        case (op_reg)
            OP_ADD, OP_SUB, OP_NEG:
                {lane_next.ov, lane_next.value} = sat32(64'(raw_reg));
            OP_SCALE:
                {lane_next.ov, lane_next.value} = sat32(sh0);
            OP_CROSS:
            begin
                if (LANE < LANES - 1)
                begin
                    {lane_next.ov, lane_next.value} = sat32(sh0 - sh1);
                end
            end
            OP_DOT:          lane_next.part = sh0;
            OP_MAG, OP_NORM: lane_next.part = p0_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

[rtl/hva_merge.sv]
`timescale 1ns / 1ps

module hva_merge
    import hva_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  ctl_t              ctl,
    input  lane_out_t         lanes [LANES],
    output mid_t              mid,
    output logic [RAD_W-1:0]  rad
);

    logic signed [63:0] dot_sum;
    logic [64:0]        sq_sum;
    logic               dot_ov;
    logic [WORD_W-1:0]  dot_val;
    mid_t               mid_next;
    mid_t               mid_reg;
    logic [RAD_W-1:0]   rad_reg;

    always_comb
    begin
        dot_sum = '0;
        sq_sum  = '0;
        for (int i = 0; i < LANES; i++)
        begin
            dot_sum = dot_sum + lanes[i].part;
            sq_sum  = sq_sum + 65'($unsigned(lanes[i].part));
        end
    end

    assign {dot_ov, dot_val} = sat32(dot_sum);

    always_comb
    begin
        mid_next          = '0;
        mid_next.op       = ctl.op;
        mid_next.a_point  = ctl.a_point;
        mid_next.a_vector = ctl.a_vector;
        mid_next.sat_mag  = |sq_sum[64:RAD_W];
        for (int i = 0; i < LANES; i++)
        begin
            mid_next.res[i]  = lanes[i].value;
            mid_next.amag[i] = lanes[i].amag;
            mid_next.aneg[i] = lanes[i].aneg;
            mid_next.ov      = mid_next.ov | lanes[i].ov;
        end
        case (ctl.op)
            OP_ADD, OP_SUB:
                mid_next.err = ctl.wbad ? ERR_BAD_W : ERR_OK;
            OP_DOT:
            begin
                mid_next.scalar = dot_val;
                mid_next.ov     = dot_ov;
            end
            OP_EQUAL:
                mid_next.eq = ctl.eq;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_reg <= mid_next;
            rad_reg <= sq_sum[RAD_W-1:0];
        end
    end

    assign mid = mid_reg;
    assign rad = rad_reg;

endmodule

[rtl/hva_sqrt.sv]
`timescale 1ns / 1ps

module hva_sqrt
    import hva_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [RAD_W-1:0]   rad_in,
    input  mid_t               pay_in,
    output logic [ROOT_W-1:0]  root_out,
    output mid_t               pay_out
);

    localparam int REM_W = ROOT_W + 2;

    // One root bit per stage, two radicand bits consumed per stage.
    logic [RAD_W-1:0]  rad_tap  [ROOT_W+1];
    logic [REM_W-1:0]  rem_tap  [ROOT_W+1];
    logic [ROOT_W-1:0] root_tap [ROOT_W+1];
    mid_t              pay_tap  [ROOT_W+1];

    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    mid_t              pay_reg  [ROOT_W];

    assign rad_tap[0]  = rad_in;
    assign rem_tap[0]  = '0;
    assign root_tap[0] = '0;
    assign pay_tap[0]  = pay_in;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [REM_W-1:0]  shifted;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            shifted   = {rem_tap[k][REM_W-3:0], rad_tap[k][RAD_W-1 -: 2]};
            trial     = {root_tap[k], 2'b01};
            ge        = shifted >= trial;
            rem_next  = ge ? (shifted - trial) : shifted;
            root_next = {root_tap[k][ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= {rad_tap[k][RAD_W-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                pay_reg[k]  <= pay_tap[k];
            end
        end

        assign rad_tap[k+1]  = rad_reg[k];
        assign rem_tap[k+1]  = rem_reg[k];
        assign root_tap[k+1] = root_reg[k];
        assign pay_tap[k+1]  = pay_reg[k];
    end

    assign root_out = root_tap[ROOT_W];
    assign pay_out  = pay_tap[ROOT_W];

endmodule

[rtl/hva_div.sv]
`timescale 1ns / 1ps

module hva_div
    import hva_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [WORD_W-1:0]       num,
    input  logic [ROOT_W-1:0]       den,
    output logic [FRAC_BITS+1:0]    quo
);

    // A component never exceeds the magnitude by more than one step, so
    // the quotient fits in FRAC_BITS + 2 bits.
    localparam int QW = FRAC_BITS + 2;
    localparam int NW = WORD_W + FRAC_BITS;
    localparam int RW = ROOT_W + 1;

    logic [NW-1:0]     num_ext;
    logic [RW-1:0]     rem_tap [QW+1];
    logic [QW-1:0]     sh_tap  [QW+1];
    logic [ROOT_W-1:0] den_tap [QW+1];

    logic [RW-1:0]     rem_reg [QW];
    logic [QW-1:0]     sh_reg  [QW];
    logic [ROOT_W-1:0] den_reg [QW];

    assign num_ext    = {num, {FRAC_BITS{1'b0}}};
    assign rem_tap[0] = RW'(num_ext[NW-1:QW]);
    assign sh_tap[0]  = num_ext[QW-1:0];
    assign den_tap[0] = den;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [RW-1:0] shifted;
        logic          ge;

        always_comb
        begin
            shifted = {rem_tap[k][RW-2:0], sh_tap[k][QW-1]};
            ge      = shifted >= RW'(den_tap[k]);
        end

        // Quotient bits enter at the bottom as numerator bits leave the top.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (shifted - RW'(den_tap[k])) : shifted;
                sh_reg[k]  <= {sh_tap[k][QW-2:0], ge};
                den_reg[k] <= den_tap[k];
            end
        end

        assign rem_tap[k+1] = rem_reg[k];
        assign sh_tap[k+1]  = sh_reg[k];
        assign den_tap[k+1] = den_reg[k];
    end

    assign quo = sh_tap[QW];

endmodule

[rtl/homogeneous_vector_alu.sv]
`timescale 1ns / 1ps

// Homogeneous 4-tuple ALU in signed fixed point (FRAC_BITS fraction bits).
// Requests enter on in_valid/in_ready with in_data (opcode, tuples A and B,
// scale factor); one result per request leaves on out_valid/out_ready with
// out_data, in request order. The tolerance register is written through
// cfg_valid/cfg_ready/cfg_data; cfg_ready is always high, so every transfer
// on that port takes effect at once. Write it only while the block is idle.
// Throughput: one request per cycle while the output is not stalled. A
// request passes the lane, merge, square root, divide and output registers in
// turn; the depth is set by the square root pipeline (one root bit per stage)
// and the four restoring dividers of normalize (one quotient bit per stage).
// The whole pipeline advances together: while a result sits in the output
// register and out_ready is low, every stage and in_ready hold.
// Reset clears all valid bits and returns the tolerance to 7; results in
// flight are dropped.
module homogeneous_vector_alu
    import hva_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_t              out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TOL_W-1:0]  cfg_data
);

    localparam int QW  = FRAC_BITS + 2;
    localparam int LAT = 3 + ROOT_W + QW;
    localparam logic signed [33:0] ONE34 = 34'sd1 <<< FRAC_BITS;

    logic                          adv;
    logic [LAT-1:0]                v_reg;
    logic                          out_valid_reg;
    out_t                          out_reg;
    out_t                          out_next;
    logic [TOL_W-1:0]              tol_reg;

    op_t                           op_in;
    logic [LANES-1:0][WORD_W-1:0]  a_vec;
    logic [LANES-1:0][WORD_W-1:0]  b_vec;
    logic signed [33:0]            w_sum;
    ctl_t                          ctl_next;
    ctl_t                          ctl_s1_reg;
    ctl_t                          ctl_s2_reg;

    lane_out_t                     lane_out [LANES];
    mid_t                          mid_m;
    logic [RAD_W-1:0]              rad_m;
    logic [ROOT_W-1:0]             root;
    mid_t                          mid_s;
    mid_t                          mid_post;
    logic [QW-1:0]                 quo [LANES];
    mid_t                          dly_reg [QW];
    mid_t                          mid_f;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    // Input decode and tolerance tests.
    assign op_in = op_t'(in_data.req_type);
    assign a_vec = {in_data.a_w, in_data.a_z, in_data.a_y, in_data.a_x};
    assign b_vec = {in_data.b_w, in_data.b_z, in_data.b_y, in_data.b_x};
    assign w_sum = (op_in == OP_ADD) ? (34'(in_data.a_w) + 34'(in_data.b_w))
                                     : (34'(in_data.a_w) - 34'(in_data.b_w));

    always_comb
    begin
        ctl_next.op       = op_in;
        ctl_next.a_point  = agree(34'(in_data.a_w), ONE34, tol_reg);
        ctl_next.a_vector = agree(34'(in_data.a_w), 34'sd0, tol_reg);
        ctl_next.wbad     = !agree(w_sum, 34'sd0, tol_reg) &&
                            !agree(w_sum, ONE34, tol_reg);
        ctl_next.eq       = agree(34'(in_data.a_x), 34'(in_data.b_x), tol_reg) &&
                            agree(34'(in_data.a_y), 34'(in_data.b_y), tol_reg) &&
                            agree(34'(in_data.a_z), 34'(in_data.b_z), tol_reg) &&
                            agree(34'(in_data.a_w), 34'(in_data.b_w), tol_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_s1_reg <= ctl_next;
            ctl_s2_reg <= ctl_s1_reg;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        hva_lane #(
            .FRAC_BITS (FRAC_BITS),
            .LANE      (i)
        ) u_lane (
            .clk      (clk),
            .en       (adv),
            .op       (op_in),
            .a_vec    (a_vec),
            .b_vec    (b_vec),
            .s        (in_data.scale_factor),
            .lane_out (lane_out[i])
        );
    end

    hva_merge u_merge (
        .clk   (clk),
        .en    (adv),
        .ctl   (ctl_s2_reg),
        .lanes (lane_out),
        .mid   (mid_m),
        .rad   (rad_m)
    );

    hva_sqrt u_sqrt (
        .clk      (clk),
        .en       (adv),
        .rad_in   (rad_m),
        .pay_in   (mid_m),
        .root_out (root),
        .pay_out  (mid_s)
    );

    always_comb
    begin
        mid_post     = mid_s;
        mid_post.mag = mid_s.sat_mag ? 32'h7FFF_FFFF : WORD_W'(root);
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_div
        hva_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num (mid_post.amag[i]),
            .den (mid_post.mag[ROOT_W-1:0]),
            .quo (quo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dly_reg[0] <= mid_post;
            for (int k = 1; k < QW; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    assign mid_f = dly_reg[QW-1];

    always_comb
    begin
        out_next.res_x         = mid_f.res[0];
        out_next.res_y         = mid_f.res[1];
        out_next.res_z         = mid_f.res[2];
        out_next.res_w         = mid_f.res[3];
        out_next.scalar_out    = mid_f.scalar;
        out_next.tuples_equal  = mid_f.eq;
        out_next.a_is_point    = mid_f.a_point;
        out_next.a_is_vector   = mid_f.a_vector;
        out_next.error_code    = mid_f.err;
        out_next.overflow_flag = mid_f.ov;
        if (mid_f.op == OP_MAG || mid_f.op == OP_NORM)
        begin
            out_next.overflow_flag = 1'b0;
            if (!mid_f.a_vector)
            begin
                out_next.error_code = ERR_NON_VECTOR;
            end
            else if (mid_f.op == OP_MAG)
            begin
                out_next.scalar_out    = mid_f.mag;
                out_next.overflow_flag = mid_f.sat_mag;
            end
            else if (mid_f.mag == '0)
            begin
                out_next.error_code = ERR_ZERO_LEN;
            end
            else
            begin
                out_next.scalar_out    = mid_f.mag;
                out_next.overflow_flag = mid_f.sat_mag;
                out_next.res_x = mid_f.aneg[0] ? -WORD_W'(quo[0]) : WORD_W'(quo[0]);
                out_next.res_y = mid_f.aneg[1] ? -WORD_W'(quo[1]) : WORD_W'(quo[1]);
                out_next.res_z = mid_f.aneg[2] ? -WORD_W'(quo[2]) : WORD_W'(quo[2]);
                out_next.res_w = mid_f.aneg[3] ? -WORD_W'(quo[3]) : WORD_W'(quo[3]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[LAT-2:0], in_valid};
            out_valid_reg <= v_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output register state");

    a_transfer_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    a_zero_len_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error_code == ERR_ZERO_LEN) |->
        (out_data.scalar_out == '0 && out_data.res_x == '0 && !out_data.overflow_flag))
        else $error("zero length result carries data");

    a_non_vector_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error_code == ERR_NON_VECTOR) |-> !out_data.a_is_vector)
        else $error("non-vector error on a vector operand");

    a_equal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.tuples_equal) |->
        (out_data.error_code == ERR_OK && !out_data.overflow_flag))
        else $error("equality result carries an error or overflow");

endmodule
